// File: design/ba32_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ba32_pkg
// Shared widths, constants and types for the blockwise Adler-32 engine.
// ----------------------------------------------------------------------------
package ba32_pkg;

    // field widths
    localparam int BYTE_W  = 8;
    localparam int SUM_W   = 16;
    localparam int CNT_W   = 17;
    localparam int CSUM_W  = 2 * SUM_W;
    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 56;

    // arithmetic constants
    localparam logic [SUM_W-1:0] ADLER_MOD = 16'd65521;
    localparam logic [CNT_W-1:0] MAX_BLOCK = 17'h10000;
    localparam logic [SUM_W-1:0] SUM_LOW_INIT  = 16'd1;
    localparam logic [SUM_W-1:0] SUM_HIGH_INIT = 16'd0;

    // one finished checksum result
    typedef struct packed {
        logic              emit;
        logic [CSUM_W-1:0] checksum;
        logic [CNT_W-1:0]  block_bytes;
        logic              final_block;
    } t_result;

endpackage
`default_nettype wire

// File: design/ba32_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ba32_core
// Running Adler-32 sums and byte count; one byte per cycle while i_advance
// is high, reports a checksum when the block fills or the stream ends.
// ----------------------------------------------------------------------------
module ba32_core (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_valid,
    input  wire logic                      i_advance,
    input  wire logic [ba32_pkg::BYTE_W-1:0] i_data_byte,
    input  wire logic                      i_stream_end,
    input  wire logic [ba32_pkg::CNT_W-1:0]  i_block_length,
    output ba32_pkg::t_result              o_result
);
    import ba32_pkg::*;

    logic [SUM_W-1:0] r_sum_low;
    logic [SUM_W-1:0] r_sum_high;
    logic [CNT_W-1:0] r_bytes;
    logic [SUM_W-1:0] n_sum_low;
    logic [SUM_W-1:0] n_sum_high;
    logic [CNT_W-1:0] n_bytes;

    logic [SUM_W:0]   low_raw;
    logic [SUM_W:0]   high_raw;
    logic [SUM_W-1:0] low_mod;
    logic [SUM_W-1:0] high_mod;
    logic [CNT_W-1:0] bytes_inc;
    logic [CNT_W-1:0] eff_len;
    logic             close_block;

    // a = (a + byte) mod 65521, then b = (b + a) mod 65521
    always_comb begin
        low_raw  = {1'b0, r_sum_low} + {{(SUM_W + 1 - BYTE_W){1'b0}}, i_data_byte};
        low_mod  = (low_raw >= {1'b0, ADLER_MOD}) ? SUM_W'(low_raw - {1'b0, ADLER_MOD})
                                                  : low_raw[SUM_W-1:0];
        high_raw = {1'b0, r_sum_high} + {1'b0, low_mod};
        high_mod = (high_raw >= {1'b0, ADLER_MOD}) ? SUM_W'(high_raw - {1'b0, ADLER_MOD})
                                                   : high_raw[SUM_W-1:0];
    end

    // saturating byte count and effective block length
    always_comb begin
        bytes_inc = (r_bytes < MAX_BLOCK) ? CNT_W'(r_bytes + 1'b1) : r_bytes;
        if (i_block_length == '0 || i_block_length > MAX_BLOCK) begin
            eff_len = MAX_BLOCK;
        end else begin
            eff_len = i_block_length;
        end
        close_block = i_stream_end || (bytes_inc >= eff_len);
    end

    // result of the item under work
    always_comb begin
        o_result.emit        = i_valid && close_block;
        o_result.checksum    = {high_mod, low_mod};
        o_result.block_bytes = bytes_inc;
        o_result.final_block = i_stream_end;
    end

    // next state: restart after a closed block
    always_comb begin
        n_sum_low  = r_sum_low;
        n_sum_high = r_sum_high;
        n_bytes    = r_bytes;
        if (i_advance) begin
            if (close_block) begin
                n_sum_low  = SUM_LOW_INIT;
                n_sum_high = SUM_HIGH_INIT;
                n_bytes    = '0;
            end else begin
                n_sum_low  = low_mod;
                n_sum_high = high_mod;
                n_bytes    = bytes_inc;
            end
        end
    end

    // sum and count registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum_low  <= SUM_LOW_INIT;
            r_sum_high <= SUM_HIGH_INIT;
            r_bytes    <= '0;
        end else begin
            r_sum_low  <= n_sum_low;
            r_sum_high <= n_sum_high;
            r_bytes    <= n_bytes;
        end
    end

endmodule
`default_nettype wire

// File: design/ba32_out_reg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ba32_out_reg
// Result register on the output stream; holds a checksum until taken.
// ----------------------------------------------------------------------------
module ba32_out_reg (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_load,
    input  wire ba32_pkg::t_result             i_result,
    input  wire logic                          i_tready,
    output logic                               o_free,
    output logic                               o_tvalid,
    output logic [ba32_pkg::M_TDATA_W-1:0]     o_tdata,
    output logic                               o_tlast
);
    import ba32_pkg::*;

    logic              r_valid;
    logic [CSUM_W-1:0] r_checksum;
    logic [CNT_W-1:0]  r_block_bytes;
    logic              r_final;

    // slot can take a new item when empty or draining this cycle
    assign o_free = !r_valid || i_tready;

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_tready) begin
            r_valid <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_checksum    <= i_result.checksum;
            r_block_bytes <= i_result.block_bytes;
            r_final       <= i_result.final_block;
        end
    end

    assign o_tvalid = r_valid;
    assign o_tdata  = {{(M_TDATA_W - CSUM_W - CNT_W){1'b0}}, r_block_bytes, r_checksum};
    assign o_tlast  = r_final;

endmodule
`default_nettype wire

// File: design/blockwise_adler32.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// blockwise_adler32
// Adler-32 checksum per fixed-length block of a byte stream.
// ----------------------------------------------------------------------------
// Path: the closing byte of a block waits in the input register until the
//   output is free, then its checksum is loaded into the result register.
// Throughput: one byte per cycle; the sum update loop sets this. A closing
//   byte stalls the input while the output still holds an untaken result.
// Reset: synchronous, active low; clears the sums (a = 1, b = 0), the byte
//   count, both valid flags, and sets the block length to 65536.
// ----------------------------------------------------------------------------
module blockwise_adler32 (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // configuration: block length
    input  wire logic                          i_cfg_wr_en,
    input  wire logic [ba32_pkg::CNT_W-1:0]    i_cfg_wr_data,
    // input stream
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    input  wire logic [ba32_pkg::S_TDATA_W-1:0] s_axis_tdata, // [7:0] data_byte
    input  wire logic                          s_axis_tlast,  // stream_end
    // output stream
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    output logic [ba32_pkg::M_TDATA_W-1:0]     m_axis_tdata,  // [31:0] checksum,
                                                              // [48:32] block_bytes,
                                                              // [55:49] zero
    output logic                               m_axis_tlast   // final_block
);
    import ba32_pkg::*;

    logic [CNT_W-1:0]  r_block_length;
    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_in_last;

    t_result core_result;
    logic    out_free;
    logic    advance;
    logic    in_fire;

    // block length register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_length <= MAX_BLOCK;
        end else if (i_cfg_wr_en) begin
            r_block_length <= i_cfg_wr_data;
        end
    end

    // item under work moves on unless its result finds the output full
    assign advance       = r_in_valid && (!core_result.emit || out_free);
    assign s_axis_tready = !r_in_valid || advance;
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_fire) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_in_byte <= s_axis_tdata[BYTE_W-1:0];
            r_in_last <= s_axis_tlast;
        end
    end

    // checksum datapath
    ba32_core u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (r_in_valid),
        .i_advance      (advance),
        .i_data_byte    (r_in_byte),
        .i_stream_end   (r_in_last),
        .i_block_length (r_block_length),
        .o_result       (core_result)
    );

    // result register
    ba32_out_reg u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (advance && core_result.emit),
        .i_result (core_result),
        .i_tready (m_axis_tready),
        .o_free   (out_free),
        .o_tvalid (m_axis_tvalid),
        .o_tdata  (m_axis_tdata),
        .o_tlast  (m_axis_tlast)
    );

endmodule
`default_nettype wire

// File: design/ba32_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ba32_checker
// Port-level checks on the blockwise Adler-32 engine, bound to the top level.
// ----------------------------------------------------------------------------
module ba32_checker (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          m_axis_tvalid,
    input wire logic                          m_axis_tready,
    input wire logic [ba32_pkg::M_TDATA_W-1:0] m_axis_tdata,
    input wire logic                          m_axis_tlast
);
    import ba32_pkg::*;

    // no result is offered right after a reset cycle
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    // a stalled result holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("stalled item changed");

    // both sums stay reduced below the modulus
    a_sums_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[15:0] < ADLER_MOD) &&
                          (m_axis_tdata[31:16] < ADLER_MOD))
        else $error("checksum half not reduced");

    // byte count lies in 1..65536 and the padding is zero
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[48:32] != '0) &&
                          (m_axis_tdata[48:32] <= MAX_BLOCK) &&
                          (m_axis_tdata[55:49] == '0))
        else $error("block byte count out of range");

endmodule

bind blockwise_adler32 ba32_checker u_ba32_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);
`default_nettype wire

// File: sim/tb_blockwise_adler32.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_blockwise_adler32
// Self-checking testbench for the per-block Adler-32 engine. A directed table
// covers the corners: sums after reset, single-byte streams, a stream end on
// a block boundary, a length cut mid-block, and length zero or above 65536.
// Random streams follow over many block lengths, with three idling mixes
// and a long output stall. Every checksum item is compared with a local
// prediction of the running sums or with a hand-computed sum from the table.
// ----------------------------------------------------------------------------
module tb_blockwise_adler32;
    import ba32_pkg::*;

    localparam int DRAIN_CYCLES = 4;

    // one expected checksum item
    typedef struct packed {
        logic [CSUM_W-1:0] checksum;
        logic [CNT_W-1:0]  block_bytes;
        logic              final_block;
    } t_sum_item;

    typedef enum logic {ROW_CFG, ROW_BYTE} t_row_kind;

    // one row of the directed table; given is used when has_given is set
    typedef struct packed {
        t_row_kind        kind;
        logic [CNT_W-1:0] value;
        logic             last;
        logic             has_given;
        t_sum_item        given;
    } t_row;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_wr_en = 1'b0;
    logic [CNT_W-1:0]       i_cfg_wr_data = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [S_TDATA_W-1:0]   s_axis_tdata = '0;  // [7:0] data_byte
    logic                   s_axis_tlast = 1'b0; // stream_end
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_axis_tdata;       // [31:0] checksum, [48:32] block_bytes
    logic                   m_axis_tlast;       // final_block

    // predicted engine state
    logic [CNT_W-1:0] acc_low = 17'd1;
    logic [CNT_W-1:0] acc_high = 17'd0;
    logic [CNT_W-1:0] acc_count = 17'd0;
    logic [CNT_W-1:0] cur_block_len = MAX_BLOCK;

    t_sum_item pending_sums[$];

    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int hold_req = 0;
    int hold_cnt = 0;
    int mismatch_count = 0;
    int bytes_sent = 0;
    int sums_checked = 0;
    int cfg_writes = 0;

    // corner cases with hand-computed sums where they are obvious
    t_row directed_rows [20] = '{
        '{ROW_BYTE, 17'h00, 1'b1, 1'b1, '{32'h00010001, 17'd1, 1'b1}},
        '{ROW_BYTE, 17'hFF, 1'b1, 1'b1, '{32'h01000100, 17'd1, 1'b1}},
        '{ROW_CFG,  17'd1,  1'b0, 1'b0, '0},
        '{ROW_BYTE, 17'hFF, 1'b0, 1'b1, '{32'h01000100, 17'd1, 1'b0}},
        '{ROW_BYTE, 17'h00, 1'b1, 1'b1, '{32'h00010001, 17'd1, 1'b1}},
        '{ROW_CFG,  17'd3,  1'b0, 1'b0, '0},
        '{ROW_BYTE, 17'h01, 1'b0, 1'b0, '0},
        '{ROW_BYTE, 17'h02, 1'b0, 1'b0, '0},
        '{ROW_BYTE, 17'h03, 1'b1, 1'b1, '{32'h000D0007, 17'd3, 1'b1}},
        '{ROW_BYTE, 17'h10, 1'b0, 1'b0, '0},
        '{ROW_BYTE, 17'h20, 1'b1, 1'b0, '0},
        '{ROW_CFG,  17'd0,  1'b0, 1'b0, '0},
        '{ROW_BYTE, 17'h80, 1'b0, 1'b0, '0},
        '{ROW_BYTE, 17'h7F, 1'b0, 1'b0, '0},
        '{ROW_BYTE, 17'hAA, 1'b0, 1'b0, '0},
        '{ROW_CFG,  17'd2,  1'b0, 1'b0, '0},
        '{ROW_BYTE, 17'h55, 1'b0, 1'b0, '0},
        '{ROW_CFG,  17'h1FFFF, 1'b0, 1'b0, '0},
        '{ROW_BYTE, 17'h01, 1'b1, 1'b0, '0},
        '{ROW_BYTE, 17'hFF, 1'b1, 1'b0, '0}
    };

    blockwise_adler32 uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // 8 ns clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // zero and out-of-range lengths mean a full 64 KiB block
    function automatic logic [CNT_W-1:0] eff_len(input logic [CNT_W-1:0] v);
        if (v == '0 || v > MAX_BLOCK) return MAX_BLOCK;
        return v;
    endfunction

    // append one expected item at the tail of the queue
    function automatic void queue_sum(input t_sum_item s);
        pending_sums.insert(pending_sums.size(), s);
    endfunction

    // fold one byte into the predicted sums; returns 1 when a block closes
    function automatic bit absorb_byte(input logic [7:0] d, input logic l,
                                       output t_sum_item r);
        r = '0;
        acc_low = acc_low + d;
        if (acc_low >= ADLER_MOD) acc_low = acc_low - ADLER_MOD;
        acc_high = acc_high + acc_low;
        if (acc_high >= ADLER_MOD) acc_high = acc_high - ADLER_MOD;
        if (acc_count < MAX_BLOCK) acc_count = acc_count + 1'b1;
        if (l || acc_count >= eff_len(cur_block_len)) begin
            r.checksum    = {acc_high[SUM_W-1:0], acc_low[SUM_W-1:0]};
            r.block_bytes = acc_count;
            r.final_block = l;
            acc_low   = 17'd1;
            acc_high  = 17'd0;
            acc_count = 17'd0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // offer one byte, wait for acceptance, then queue what it should produce
    task automatic send_byte(input logic [7:0] d, input logic l,
                             input bit use_given, input t_sum_item given);
        t_sum_item predicted;
        bit        closes;
        while ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= d;
        s_axis_tlast  <= l;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        closes = absorb_byte(d, l, predicted);
        if (use_given) queue_sum(given);
        else if (closes) queue_sum(predicted);
        bytes_sent++;
    endtask

    // block length is only changed with the engine drained
    task automatic write_block_length(input logic [CNT_W-1:0] v);
        s_axis_tvalid <= 1'b0;
        while (pending_sums.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        cur_block_len = v;
        cfg_writes++;
    endtask

    // output side: random back-pressure plus an optional long hold
    always @(posedge i_clk) begin
        if (hold_cnt == 0 && hold_req != 0) begin
            hold_cnt = hold_req;
            hold_req = 0;
        end
        if (hold_cnt != 0) begin
            hold_cnt = hold_cnt - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // compare each checksum item with the oldest prediction
    always @(posedge i_clk) begin : check_out
        t_sum_item want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_sums.size() == 0) begin
                $error("unexpected checksum item: checksum %h block_bytes %0d",
                       m_axis_tdata[31:0], m_axis_tdata[48:32]);
                mismatch_count++;
            end else begin
                want = pending_sums.pop_front();
                if (m_axis_tdata[31:0] !== want.checksum) begin
                    $error("checksum: expected %h, actual %h",
                           want.checksum, m_axis_tdata[31:0]);
                    mismatch_count++;
                end
                if (m_axis_tdata[48:32] !== want.block_bytes) begin
                    $error("block_bytes: expected %0d, actual %0d",
                           want.block_bytes, m_axis_tdata[48:32]);
                    mismatch_count++;
                end
                if (m_axis_tlast !== want.final_block) begin
                    $error("final_block: expected %b, actual %b",
                           want.final_block, m_axis_tlast);
                    mismatch_count++;
                end
                sums_checked++;
            end
        end
    end

    // stimulus
    initial begin
        logic [CNT_W-1:0] len;
        logic [7:0]       b;
        int               lim;
        int               n;
        int               sent_in_run;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    tx_idle_pct = 9;
                    rx_idle_pct = 64;
                end
                1: begin
                    tx_idle_pct = 64;
                    rx_idle_pct = 9;
                end
                default: begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase

            // corners, straight after reset
            if (phase == 0) begin
                foreach (directed_rows[i]) begin
                    if (directed_rows[i].kind == ROW_CFG)
                        write_block_length(directed_rows[i].value);
                    else
                        send_byte(directed_rows[i].value[7:0], directed_rows[i].last,
                                  directed_rows[i].has_given, directed_rows[i].given);
                end
            end

            // long output stall with one-byte blocks fills the engine
            if (phase == 2) begin
                write_block_length(17'd1);
                hold_req = 400;
                repeat (60) send_byte(8'($urandom_range(255)), 1'($urandom_range(1)),
                                      1'b0, '0);
            end

            // random streams over a spread of block lengths
            for (int run = 0; run < 4; run++) begin
                case ($urandom_range(5))
                    0: len = 17'd1;
                    1: len = 17'd2;
                    2: len = CNT_W'($urandom_range(3, 16));
                    3: len = CNT_W'($urandom_range(17, 300));
                    4: len = MAX_BLOCK;
                    default: len = $urandom_range(1) ? 17'd0
                                                     : CNT_W'($urandom_range(65537, 131071));
                endcase
                write_block_length(len);
                sent_in_run = 0;
                while (sent_in_run < 85) begin
                    if ($urandom_range(7) == 0) begin
                        // loose bytes with stream ends at random
                        n = $urandom_range(1, 12);
                        repeat (n) send_byte(8'($urandom_range(255)), $urandom_range(2) == 0,
                                             1'b0, '0);
                    end else begin
                        // well-formed stream, heavy on 0xff to push the sums to wrap
                        lim = 3 * int'(eff_len(len)) + 2;
                        if (lim > 200) lim = 200;
                        n = $urandom_range(1, lim);
                        for (int k = 1; k <= n; k++) begin
                            b = ($urandom_range(3) == 0) ? 8'hFF : 8'($urandom_range(255));
                            send_byte(b, k == n, 1'b0, '0);
                        end
                    end
                    sent_in_run += n;
                end
            end
        end

        // drain
        s_axis_tvalid <= 1'b0;
        while (pending_sums.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("covered %0d bytes, %0d checksums, %0d block length writes",
                 bytes_sent, sums_checked, cfg_writes);
        $display("three idling mixes and a long output stall with the input held off");
        if (mismatch_count == 0) begin
            $display("blockwise_adler32: match");
        end else begin
            $display("blockwise_adler32: mismatch");
        end
        $finish;
    end

    // watchdog
    initial begin
        #10_000_000;
        $display("blockwise_adler32: mismatch");
        $finish;
    end

endmodule

// File: sim.f
design/ba32_pkg.sv
design/ba32_core.sv
design/ba32_out_reg.sv
design/blockwise_adler32.sv
design/ba32_checker.sv
sim/tb_blockwise_adler32.sv
